// ===== design/vurp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vurp_pkg;

    localparam int DOT_W  = 9;
    localparam int LINE_W = 10;

    localparam int DOTS_PER_LINE_DEF   = 341;
    localparam int LINES_PER_FRAME_DEF = 262;
    localparam int VBLANK_LINE_DEF     = 241;

    localparam int SPACE_AW = 14;
    localparam int PAT_AW   = 13;
    localparam int NT_AW    = 11;
    localparam int PAL_AW   = 5;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDRESS = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    localparam logic [5:0] PAL_PAGE = 6'h3F;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [SPACE_AW-1:0] addr;
        logic [7:0]          wdata;
    } t_mem_req;

    typedef struct packed {
        logic       load_buf;
        logic       use_new;
        logic [7:0] rd_base;
        logic       nmi;
        logic       done;
        logic       vblank;
    } t_item_res;

    function automatic logic is_palette(input logic [SPACE_AW-1:0] a);
        return a[SPACE_AW-1:8] == PAL_PAGE;
    endfunction

    function automatic logic is_pattern(input logic [SPACE_AW-1:0] a);
        return ~a[SPACE_AW-1];
    endfunction

    function automatic logic [NT_AW-1:0] nt_index(input logic [SPACE_AW-1:0] a,
                                                  input logic mirror);
        logic bank;
        bank = mirror ? a[11] : a[10];
        return {bank, a[9:0]};
    endfunction

    function automatic logic [PAL_AW-1:0] pal_index(input logic [SPACE_AW-1:0] a);
        logic [PAL_AW-1:0] p;
        p = a[PAL_AW-1:0];
        if (p[4] && (p[1:0] == 2'b00)) begin
            p[4] = 1'b0;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== design/video_unit_register_port_and_timing_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Register port and dot timing of a tile-based video unit. One request (dot
// tick, register read or register write) is taken every cycle while o_in_ready
// is high; each gives one result, passing first through the synchronous read
// of video memory and then through the output register, which holds while
// i_out_ready is low. The read buffer is forwarded from the memory port, so
// back-to-back data reads need no gap. After reset a clearing pass zeroes
// pattern, nametable and palette memory with o_in_ready low; mirror_mode may
// be written during it.

module video_unit_register_port_and_timing_unit #(
    parameter int DOTS_PER_LINE   = vurp_pkg::DOTS_PER_LINE_DEF,
    parameter int LINES_PER_FRAME = vurp_pkg::LINES_PER_FRAME_DEF,
    parameter int VBLANK_LINE     = vurp_pkg::VBLANK_LINE_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_command,
    input  wire logic [2:0] i_reg_index,
    input  wire logic [7:0] i_write_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_read_data,
    output logic            o_nmi_raise,
    output logic            o_frame_done,
    output logic            o_vblank_flag,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data
);
    import vurp_pkg::*;

    t_mem_req   mem_req;
    t_item_res  res;
    logic [7:0] mem_rdata;
    logic       clr_busy;
    logic       mirror_mode;

    logic       r_s1_valid;
    t_item_res  r_s1;
    logic [7:0] r_read_buffer;
    logic       r_out_valid;
    logic [7:0] r_read_data;
    logic       r_nmi_raise;
    logic       r_frame_done;
    logic       r_vblank_flag;

    logic       out_free;
    logic       s1_move;
    logic       accept;
    logic [7:0] eff_buf;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !clr_busy && (!r_s1_valid || out_free);
    assign accept     = i_in_valid && o_in_ready;
    assign eff_buf    = (r_s1_valid && r_s1.load_buf) ? mem_rdata : r_read_buffer;

    vurp_regs #(
        .DOTS_PER_LINE   (DOTS_PER_LINE),
        .LINES_PER_FRAME (LINES_PER_FRAME),
        .VBLANK_LINE     (VBLANK_LINE)
    ) u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_command     (i_command),
        .i_reg_index   (i_reg_index),
        .i_write_data  (i_write_data),
        .i_read_buffer (eff_buf),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_mem_req     (mem_req),
        .o_res         (res),
        .o_mirror_mode (mirror_mode)
    );

    vurp_vram u_vram (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mirror_mode (mirror_mode),
        .i_req         (mem_req),
        .o_rdata       (mem_rdata),
        .o_clr_busy    (clr_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_read_buffer <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_move && r_s1.load_buf) begin
                r_read_buffer <= mem_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= res;
        end
        if (s1_move) begin
            r_read_data   <= r_s1.use_new ? mem_rdata : r_s1.rd_base;
            r_nmi_raise   <= r_s1.nmi;
            r_frame_done  <= r_s1.done;
            r_vblank_flag <= r_s1.vblank;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_nmi_raise   = r_nmi_raise;
    assign o_frame_done  = r_frame_done;
    assign o_vblank_flag = r_vblank_flag;

endmodule

`default_nettype wire

// ===== design/vurp_vram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vurp_vram (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_mirror_mode,
    input  wire vurp_pkg::t_mem_req i_req,
    output logic [7:0]             o_rdata,
    output logic                   o_clr_busy
);
    import vurp_pkg::*;

    logic [7:0] r_pat [0:(1 << PAT_AW)-1];
    logic [7:0] r_nt  [0:(1 << NT_AW)-1];
    logic [7:0] r_pal [0:(1 << PAL_AW)-1];

    logic [7:0]        r_pat_q;
    logic [7:0]        r_nt_q;
    logic [7:0]        r_pal_q;
    logic              r_sel_pat;
    logic              r_sel_pal;
    logic              r_clr_busy;
    logic [PAT_AW-1:0] r_clr_addr;

    logic              a_pat;
    logic              a_pal;
    logic [NT_AW-1:0]  nt_addr;
    logic [PAL_AW-1:0] pal_addr;

    assign a_pat    = is_pattern(i_req.addr);
    assign a_pal    = is_palette(i_req.addr);
    assign nt_addr  = nt_index(i_req.addr, i_mirror_mode);
    assign pal_addr = pal_index(i_req.addr);

    // clear all stores after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + PAT_AW'(1);
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_pat[r_clr_addr] <= '0;
        end else if (i_req.wr_en && a_pat) begin
            r_pat[i_req.addr[PAT_AW-1:0]] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_pat_q <= r_pat[i_req.addr[PAT_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_nt[r_clr_addr[NT_AW-1:0]] <= '0;
        end else if (i_req.wr_en && !a_pat && !a_pal) begin
            r_nt[nt_addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_nt_q <= r_nt[nt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_pal[r_clr_addr[PAL_AW-1:0]] <= '0;
        end else if (i_req.wr_en && a_pal) begin
            r_pal[pal_addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_pal_q   <= r_pal[pal_addr];
            r_sel_pat <= a_pat;
            r_sel_pal <= a_pal;
        end
    end

    assign o_rdata    = r_sel_pat ? r_pat_q : (r_sel_pal ? r_pal_q : r_nt_q);
    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

// ===== design/vurp_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vurp_regs #(
    parameter int DOTS_PER_LINE   = vurp_pkg::DOTS_PER_LINE_DEF,
    parameter int LINES_PER_FRAME = vurp_pkg::LINES_PER_FRAME_DEF,
    parameter int VBLANK_LINE     = vurp_pkg::VBLANK_LINE_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [1:0]          i_command,
    input  wire logic [2:0]          i_reg_index,
    input  wire logic [7:0]          i_write_data,
    input  wire logic [7:0]          i_read_buffer,
    input  wire logic                i_cfg_wr_en,
    input  wire logic                i_cfg_wr_data,
    output vurp_pkg::t_mem_req       o_mem_req,
    output vurp_pkg::t_item_res      o_res,
    output logic                     o_mirror_mode
);
    import vurp_pkg::*;

    localparam logic [DOT_W-1:0]         DOT_LAST  = DOT_W'(DOTS_PER_LINE - 1);
    localparam logic [DOT_W-1:0]         DOT_EDGE  = DOT_W'(1);
    localparam logic signed [LINE_W-1:0] LINE_LAST = LINE_W'(LINES_PER_FRAME - 2);
    localparam logic signed [LINE_W-1:0] LINE_VBL  = LINE_W'(VBLANK_LINE);
    localparam logic signed [LINE_W-1:0] LINE_PRE  = '1;

    logic [7:0]               r_control, n_control;
    logic                     r_vblank, n_vblank;
    logic                     r_toggle, n_toggle;
    logic [15:0]              r_pointer, n_pointer;
    logic [DOT_W-1:0]         r_dot, n_dot;
    logic signed [LINE_W-1:0] r_line, n_line;
    logic                     r_mirror;

    logic [15:0]         inc;
    logic [SPACE_AW-1:0] addr;

    always_comb begin
        n_control = r_control;
        n_vblank  = r_vblank;
        n_toggle  = r_toggle;
        n_pointer = r_pointer;
        n_dot     = r_dot;
        n_line    = r_line;
        o_mem_req = '0;
        o_res     = '0;
        inc       = r_control[2] ? 16'd32 : 16'd1;
        addr      = r_pointer[SPACE_AW-1:0];
        o_mem_req.addr  = addr;
        o_mem_req.wdata = i_write_data;
        if (i_accept) begin
            case (i_command)
                CMD_TICK: begin
                    if (r_dot == DOT_EDGE) begin
                        if (r_line == LINE_PRE) begin
                            n_vblank = 1'b0;
                        end
                        if (r_line == LINE_VBL) begin
                            n_vblank  = 1'b1;
                            o_res.nmi = r_control[7];
                        end
                    end
                    if (r_dot >= DOT_LAST) begin
                        n_dot = '0;
                        if (r_line >= LINE_LAST) begin
                            n_line     = LINE_PRE;
                            o_res.done = 1'b1;
                        end else begin
                            n_line = r_line + LINE_W'(1);
                        end
                    end else begin
                        n_dot = r_dot + DOT_W'(1);
                    end
                end
                CMD_READ: begin
                    case (i_reg_index)
                        REG_STATUS: begin
                            o_res.rd_base = {r_vblank, 2'b00, i_read_buffer[4:0]};
                            n_vblank      = 1'b0;
                            n_toggle      = 1'b0;
                        end
                        REG_DATA: begin
                            o_res.rd_base   = i_read_buffer;
                            o_res.load_buf  = 1'b1;
                            o_res.use_new   = is_palette(addr);
                            o_mem_req.rd_en = 1'b1;
                            n_pointer       = r_pointer + inc;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_WRITE: begin
                    case (i_reg_index)
                        REG_CONTROL: begin
                            n_control = i_write_data;
                        end
                        REG_SCROLL: begin
                            n_toggle = ~r_toggle;
                        end
                        REG_ADDRESS: begin
                            if (!r_toggle) begin
                                n_pointer = {i_write_data, r_pointer[7:0]};
                            end else begin
                                n_pointer = {r_pointer[15:8], i_write_data};
                            end
                            n_toggle = ~r_toggle;
                        end
                        REG_DATA: begin
                            o_mem_req.wr_en = 1'b1;
                            n_pointer       = r_pointer + inc;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        o_res.vblank = n_vblank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= '0;
            r_vblank  <= 1'b0;
            r_toggle  <= 1'b0;
            r_pointer <= '0;
            r_dot     <= '0;
            r_line    <= '0;
            r_mirror  <= 1'b0;
        end else begin
            r_control <= n_control;
            r_vblank  <= n_vblank;
            r_toggle  <= n_toggle;
            r_pointer <= n_pointer;
            r_dot     <= n_dot;
            r_line    <= n_line;
            if (i_cfg_wr_en) begin
                r_mirror <= i_cfg_wr_data;
            end
        end
    end

    assign o_mirror_mode = r_mirror;

endmodule

`default_nettype wire

// ===== design/vurp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vurp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_read_data,
    input wire logic       o_nmi_raise,
    input wire logic       o_frame_done,
    input wire logic       o_vblank_flag
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data)
            && $stable(o_vblank_flag))
        else $error("result dropped or changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("port active straight after reset");

    a_nmi_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_nmi_raise |-> o_vblank_flag && !o_frame_done)
        else $error("interrupt without vblank");

    a_tick_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_frame_done || o_nmi_raise) |-> o_read_data == 8'd0)
        else $error("tick result carries read data");

endmodule

bind video_unit_register_port_and_timing_unit vurp_checker u_vurp_checker (.*);

`default_nettype wire
